// ===== rtl/core/fpba_pkg.sv =====
// shared types and constants of the fit policy block allocator
package fpba_pkg;

	localparam int ACTION_W   = 1;
	localparam int BLK_NUM_W  = 4;
	localparam int AMOUNT_W   = 16;
	localparam int CFG_DATA_W = 5;

	localparam logic [ACTION_W-1:0] ACT_LOAD    = 1'b0;
	localparam logic [ACTION_W-1:0] ACT_REQUEST = 1'b1;

	localparam logic [1:0] POLICY_FIRST = 2'd0;
	localparam logic [1:0] POLICY_BEST  = 2'd1;
	localparam logic [1:0] POLICY_WORST = 2'd2;

	localparam logic [CFG_DATA_W-1:0] BLOCKS_IN_USE_RESET = 5'd16;

	typedef enum logic [0:0] {
		CFG_FIT_POLICY    = 1'b0,
		CFG_BLOCKS_IN_USE = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic load;
		logic start_req;
		logic issue;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic issue_done;
		logic rd_pending;
	} dp_status_t;

endpackage

// ===== rtl/core/fpba_ctrl.sv =====
// controller state machine of the fit policy block allocator
module fpba_ctrl
	import fpba_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [ACTION_W-1:0] action,
	output logic                busy,
	input  dp_status_t          status,
	output dp_cmd_t             cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   busy_q;

	assign busy = busy_q;

	always_comb begin
		cmd           = '0;
		cmd.load      = start && !busy_q && (action == ACT_LOAD);
		cmd.start_req = start && !busy_q && (action == ACT_REQUEST);
		cmd.issue     = (state_q == ST_SCAN) && !status.issue_done;
		cmd.commit    = (state_q == ST_COMMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start_req) begin
						state_q <= ST_SCAN;
						busy_q  <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (status.issue_done && !status.rd_pending) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_commit_frees: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> !busy_q)
		else $error("busy still set after commit");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_req |=> busy_q)
		else $error("request accepted but busy not raised");
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> $past(start) && $past(action == ACT_REQUEST))
		else $error("busy raised without a request");
`endif

endmodule

// ===== rtl/core/fpba_dp.sv =====
// datapath of the fit policy block allocator: size table, scan and result registers
module fpba_dp
	import fpba_pkg::*;
#(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	output dp_status_t            status,
	input  logic [BLK_NUM_W-1:0]  block_number,
	input  logic [AMOUNT_W-1:0]   amount,
	input  logic                  cfg_we,
	input  cfg_index_t            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  done,
	output logic                  granted,
	output logic [BLK_NUM_W-1:0]  chosen_block,
	output logic [AMOUNT_W-1:0]   left_over
);

	localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

	logic [SIZE_BITS-1:0] mem [NUM_BLOCKS];
	logic [NUM_BLOCKS-1:0] valid_q;

	logic [1:0]            policy_q;
	logic [CFG_DATA_W-1:0] blocks_in_use_q;

	logic [SIZE_BITS-1:0] amt_q;
	logic [CNT_W-1:0]     idx_q;
	logic [IDX_W-1:0]     idx_s1;
	logic                 rd_pending_s1;
	logic [SIZE_BITS-1:0] rd_data_s1;
	logic                 rd_ok_s1;
	logic                 found_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [SIZE_BITS-1:0] best_size_q;

	logic                 done_q;
	logic                 granted_q;
	logic [BLK_NUM_W-1:0] chosen_block_q;
	logic [AMOUNT_W-1:0]  left_over_q;

	logic [31:0]          amount_wide;
	logic [SIZE_BITS-1:0] amt_in;
	logic [31:0]          blk_wide;
	logic                 blk_in_range;
	logic [31:0]          limit_wide;
	logic [SIZE_BITS-1:0] sz;
	logic                 fits;
	logic                 take;
	logic [SIZE_BITS-1:0] remain;
	logic [31:0]          remain_wide;
	logic [31:0]          best_idx_wide;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	logic [SIZE_BITS-1:0] wr_data;

	assign amount_wide  = 32'(amount);
	assign amt_in       = amount_wide[SIZE_BITS-1:0];
	assign blk_wide     = 32'(block_number);
	assign blk_in_range = blk_wide < NUM_BLOCKS;
	assign limit_wide   = (32'(blocks_in_use_q) > NUM_BLOCKS) ? 32'(NUM_BLOCKS)
	                                                          : 32'(blocks_in_use_q);

	assign status.issue_done = 32'(idx_q) >= limit_wide;
	assign status.rd_pending = rd_pending_s1;

	assign sz   = rd_ok_s1 ? rd_data_s1 : '0;
	assign fits = sz >= amt_q;

	always_comb begin
		take = 1'b0;
		unique case (policy_q)
			POLICY_BEST:  take = fits && (!found_q || (sz < best_size_q));
			POLICY_WORST: take = fits && (!found_q || (sz > best_size_q));
			default:      take = fits && !found_q;
		endcase
	end

	assign remain        = best_size_q - amt_q;
	assign remain_wide   = 32'(remain);
	assign best_idx_wide = 32'(best_idx_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = best_idx_q;
		wr_data = remain;
		if (cmd.load) begin
			wr_en   = blk_in_range;
			wr_addr = blk_wide[IDX_W-1:0];
			wr_data = amt_in;
		end else if (cmd.commit) begin
			wr_en = found_q;
		end
	end

	// size table
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.issue) begin
			rd_data_s1 <= mem[idx_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_ok_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (cmd.issue) begin
				rd_ok_s1 <= valid_q[idx_q[IDX_W-1:0]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q        <= POLICY_FIRST;
			blocks_in_use_q <= BLOCKS_IN_USE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FIT_POLICY:    policy_q        <= cfg_data[1:0];
				CFG_BLOCKS_IN_USE: blocks_in_use_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q         <= '0;
			rd_pending_s1 <= 1'b0;
			found_q       <= 1'b0;
		end else begin
			rd_pending_s1 <= cmd.issue;
			if (cmd.start_req) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.issue) begin
					idx_q <= idx_q + 1'b1;
				end
				if (rd_pending_s1 && take) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_req) begin
			amt_q <= amt_in;
		end
		if (cmd.issue) begin
			idx_s1 <= idx_q[IDX_W-1:0];
		end
		if (rd_pending_s1 && take) begin
			best_idx_q  <= idx_s1;
			best_size_q <= sz;
		end
	end

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.commit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			granted_q      <= found_q;
			chosen_block_q <= found_q ? best_idx_wide[BLK_NUM_W-1:0] : '0;
			left_over_q    <= found_q ? remain_wide[AMOUNT_W-1:0] : '0;
		end
	end

	assign done         = done_q;
	assign granted      = granted_q;
	assign chosen_block = chosen_block_q;
	assign left_over    = left_over_q;

`ifndef SYNTH
	a_done_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(cmd.commit))
		else $error("result word without commit");
	a_found_fits: assert property (@(posedge clk) disable iff (!arst_n)
		found_q && !cmd.start_req |=> !found_q || (best_size_q >= amt_q))
		else $error("chosen block smaller than request");
	a_pending_follows_issue: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pending_s1 |-> $past(cmd.issue))
		else $error("read data pending without a read");
`endif

endmodule

// ===== rtl/core/fit_policy_block_allocator.sv =====
// top level of the fit policy block allocator
// A load (action 0) writes one block's free size;
// busy stays low and no result word follows. A request (action 1) raises busy
// and scans the first min(blocks_in_use, NUM_BLOCKS) table entries, one
// single-port table read per cycle, then commits the chosen block. The
// result word appears on done for one cycle as busy falls. Results
// cannot be held off, so a word must be taken in the cycle done is high. The
// free size table reads as zero after reset with no clearing pass; the
// configuration port is always ready and is meant to be written while idle.
module fit_policy_block_allocator
	import fpba_pkg::*;
#(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [ACTION_W-1:0]   action,
	input  logic [BLK_NUM_W-1:0]  block_number,
	input  logic [AMOUNT_W-1:0]   amount,
	output logic                  done,
	output logic                  granted,
	output logic [BLK_NUM_W-1:0]  chosen_block,
	output logic [AMOUNT_W-1:0]   left_over,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  cfg_index_t            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	fpba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	fpba_dp #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.SIZE_BITS  (SIZE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.block_number (block_number),
		.amount       (amount),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.granted      (granted),
		.chosen_block (chosen_block),
		.left_over    (left_over)
	);

endmodule

// ===== bench/fpba_checker.sv =====
// checker that predicts the allocator's placement words and compares them with the block
module fpba_checker
	import fpba_pkg::*;
#(
	parameter int NUM_BLOCKS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  logic [ACTION_W-1:0]   action,
	input  logic [BLK_NUM_W-1:0]  block_number,
	input  logic [AMOUNT_W-1:0]   amount,
	input  logic                  done,
	input  logic                  granted,
	input  logic [BLK_NUM_W-1:0]  chosen_block,
	input  logic [AMOUNT_W-1:0]   left_over,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  cfg_index_t            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    words_pending
);

	typedef struct packed {
		logic                 granted;
		logic [BLK_NUM_W-1:0] blk;
		logic [AMOUNT_W-1:0]  left;
	} placement_t;

	placement_t            expected_placements[$];
	logic [AMOUNT_W-1:0]   free_table [NUM_BLOCKS];
	logic [1:0]            fit_mode;
	logic [CFG_DATA_W-1:0] span;

	task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch on %s at %0t: got %0h, expected %0h", field, $time, got, want);
		mismatches++;
	endtask

	task automatic predict_placement(input logic [AMOUNT_W-1:0] need);
		int         lim;
		int         pick;
		bit         found;
		placement_t p;
		lim = (span > NUM_BLOCKS) ? NUM_BLOCKS : span;
		pick = 0;
		found = 1'b0;
		for (int j = 0; j < lim; j++) begin
			if (free_table[j] < need)
				continue;
			if (!found) begin
				found = 1'b1;
				pick = j;
				if (fit_mode != POLICY_BEST && fit_mode != POLICY_WORST)
					break;
			end else if (fit_mode == POLICY_BEST && free_table[j] < free_table[pick]) begin
				pick = j;
			end else if (fit_mode == POLICY_WORST && free_table[j] > free_table[pick]) begin
				pick = j;
			end
		end
		p = '0;
		if (found) begin
			free_table[pick] = free_table[pick] - need;
			p.granted = 1'b1;
			p.blk = pick[BLK_NUM_W-1:0];
			p.left = free_table[pick];
		end
		expected_placements.push_back(p);
	endtask

	always @(posedge clk or negedge arst_n) begin : sample
		placement_t want;
		if (!arst_n) begin
			foreach (free_table[k])
				free_table[k] = '0;
			fit_mode = POLICY_FIRST;
			span = BLOCKS_IN_USE_RESET;
			expected_placements.delete();
			mismatches = 0;
		end else begin
			if (done === 1'b1) begin
				if (expected_placements.size() == 0) begin
					report("word with none expected",
						32'({granted, chosen_block, left_over}), 32'd0);
				end else begin
					want = expected_placements.pop_front();
					if (granted !== want.granted)
						report("granted", 32'(granted), 32'(want.granted));
					if (chosen_block !== want.blk)
						report("chosen_block", 32'(chosen_block), 32'(want.blk));
					if (left_over !== want.left)
						report("left_over", 32'(left_over), 32'(want.left));
				end
			end else if (done !== 1'b0) begin
				report("done", 32'(done), 32'd0);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FIT_POLICY:    fit_mode = cfg_data[1:0];
					CFG_BLOCKS_IN_USE: span = cfg_data;
					default:           ;
				endcase
			end
			if (start && busy === 1'b0) begin
				if (action == ACT_LOAD) begin
					if (block_number < NUM_BLOCKS)
						free_table[block_number] = amount;
				end else begin
					predict_placement(amount);
				end
			end
		end
		words_pending = expected_placements.size();
	end

endmodule

// ===== bench/fit_policy_block_allocator_tb.sv =====
// testbench top: drives loads, requests and register writes, and gives the verdict
module fit_policy_block_allocator_tb;
	import fpba_pkg::*;

	localparam logic [1:0] POLICY_SPARE   = 2'd3;
	localparam int         WATCHDOG_LIMIT = 1000;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [ACTION_W-1:0]   action;
	logic [BLK_NUM_W-1:0]  block_number;
	logic [AMOUNT_W-1:0]   amount;
	logic                  done;
	logic                  granted;
	logic [BLK_NUM_W-1:0]  chosen_block;
	logic [AMOUNT_W-1:0]   left_over;
	logic                  cfg_valid;
	logic                  cfg_ready;
	cfg_index_t            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    words_pending;
	int                    idle_pct = 0;
	int                    quiet_cycles = 0;

	fit_policy_block_allocator i_dut (.*);

	fpba_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_word(input logic [ACTION_W-1:0] act, input logic [BLK_NUM_W-1:0] blk,
			input logic [AMOUNT_W-1:0] amt);
		@(negedge clk);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 20)) @(negedge clk);
		end
		start <= 1'b1;
		action <= act;
		block_number <= blk;
		amount <= amt;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (words_pending != 0 || busy) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(input logic [1:0] pol, input logic [CFG_DATA_W-1:0] n);
		settle();
		write_reg(CFG_FIT_POLICY, {3'($urandom), pol});
		write_reg(CFG_BLOCKS_IN_USE, n);
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] n;
		logic [AMOUNT_W-1:0]   amt;
		int                    pick;
		arst_n = 1'b0;
		start = 1'b0;
		action = ACT_LOAD;
		block_number = '0;
		amount = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_FIT_POLICY;
		cfg_data = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// zero request and no fit on the cleared table
		send_word(ACT_REQUEST, 4'd5, 16'd0);
		send_word(ACT_REQUEST, 4'd0, 16'd1);
		send_word(ACT_LOAD, 4'd0, 16'd100);
		send_word(ACT_LOAD, 4'd3, 16'd40);
		send_word(ACT_LOAD, 4'd7, 16'd60);
		send_word(ACT_LOAD, 4'd15, 16'hFFFF);
		send_word(ACT_REQUEST, 4'd0, 16'd30);
		configure(POLICY_BEST, 5'd16);
		send_word(ACT_REQUEST, 4'd0, 16'd30);
		send_word(ACT_REQUEST, 4'd15, 16'hFFFF);
		configure(POLICY_WORST, 5'd16);
		send_word(ACT_REQUEST, 4'd0, 16'd5);
		// tie on the largest size
		send_word(ACT_LOAD, 4'd7, 16'd65);
		send_word(ACT_REQUEST, 4'd0, 16'd1);
		configure(POLICY_SPARE, 5'd16);
		send_word(ACT_REQUEST, 4'd0, 16'd60);
		configure(POLICY_FIRST, 5'd0);
		send_word(ACT_REQUEST, 4'd0, 16'd0);
		configure(POLICY_WORST, 5'd31);
		send_word(ACT_LOAD, 4'd15, 16'hFFFF);
		send_word(ACT_REQUEST, 4'd0, 16'hFFFF);
		// load beyond the blocks in use is kept for later
		configure(POLICY_FIRST, 5'd1);
		send_word(ACT_LOAD, 4'd9, 16'd50);
		send_word(ACT_REQUEST, 4'd0, 16'd40);
		configure(POLICY_BEST, 5'd10);
		send_word(ACT_REQUEST, 4'd0, 16'd40);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0:       n = 5'd16;
				1:       n = 5'd1;
				2:       n = 5'd31;
				3:       n = 5'($urandom_range(2, 15));
				4:       n = 5'd0;
				default: n = 5'd16;
			endcase
			configure(2'($urandom_range(0, 3)), n);
			case (ph % 3)
				0:       idle_pct = 0;
				1:       idle_pct = 62;
				default: idle_pct = 21;
			endcase
			repeat (90) begin
				pick = $urandom_range(99);
				if (pick < 45) begin
					case ($urandom_range(3))
						0:       amt = 16'($urandom);
						1:       amt = 16'hFFFF;
						2:       amt = 16'($urandom_range(0, 255));
						default: amt = 16'($urandom_range(16'h8000, 16'hFFFF));
					endcase
					send_word(ACT_LOAD, 4'($urandom), amt);
				end else begin
					case ($urandom_range(19))
						0, 1:          amt = $urandom_range(1) ? 16'hFFFF : 16'd0;
						2, 3, 4:       amt = 16'($urandom);
						5, 6, 7, 8, 9: amt = 16'($urandom_range(0, 4095));
						default:       amt = 16'($urandom_range(0, 255));
					endcase
					send_word(ACT_REQUEST, 4'($urandom), amt);
				end
			end
		end

		idle_pct = 0;
		settle();
		repeat (16) @(negedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/fpba_pkg.sv
rtl/core/fpba_ctrl.sv
rtl/core/fpba_dp.sv
rtl/core/fit_policy_block_allocator.sv
bench/fpba_checker.sv
bench/fit_policy_block_allocator_tb.sv
